@@ rtl/core/arp_resolution_cache_macros.svh @@
// assertion macros for the arp resolution cache
// used by rtl/core modules that carry concurrent assertions
`ifndef ARP_RESOLUTION_CACHE_MACROS_SVH
`define ARP_RESOLUTION_CACHE_MACROS_SVH
// implication checked on every clock, disabled in reset
`define ARC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/arc_pkg.sv @@
// shared types and constants for the arp resolution cache
// no dependencies
package arc_pkg;
    localparam int TableDepth = 16;
    localparam int IdxBits    = $clog2(TableDepth);
    localparam int TagBits    = 8;

    localparam logic [1:0] REQ_OUT   = 2'd0;
    localparam logic [1:0] REQ_ARP   = 2'd1;
    localparam logic [1:0] REQ_ADD   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] AT_NONE  = 2'd0;
    localparam logic [1:0] AT_INET  = 2'd1;
    localparam logic [1:0] AT_ILINK = 2'd2;
    localparam logic [1:0] AT_OTHER = 2'd3;

    localparam logic [2:0] ACT_SEND      = 3'd0;
    localparam logic [2:0] ACT_DROP      = 3'd1;
    localparam logic [2:0] ACT_SEND_HELD = 3'd2;
    localparam logic [2:0] ACT_REPLY     = 3'd3;
    localparam logic [2:0] ACT_REQUEST   = 3'd4;
    localparam logic [2:0] ACT_FREE      = 3'd5;

    localparam logic [1:0] CFG_OWN_IP       = 2'd0;
    localparam logic [1:0] CFG_OWN_IP_VALID = 2'd1;
    localparam logic [1:0] CFG_OWN_MAC      = 2'd2;
    localparam logic [1:0] CFG_MAX_REQ      = 2'd3;

    localparam logic [31:0] BCAST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [TagBits-1:0] pkt_tag;
        logic [1:0]         addr_kind;
        logic [31:0]        dest_ip;
        logic [31:0]        hop_addr;
        logic               arp_opcode;
        logic [31:0]        sender_ip;
        logic [31:0]        sender_mac;
        logic [31:0]        target_ip;
    } t_req;

    typedef struct packed {
        logic [2:0]         action;
        logic [TagBits-1:0] out_tag;
        logic [31:0]        mac_dest;
        logic [31:0]        mac_source;
        logic               out_arp_op;
        logic [31:0]        out_sender_ip;
        logic [31:0]        out_sender_mac;
        logic [31:0]        out_target_ip;
        logic [31:0]        out_target_mac;
        logic [31:0]        link_seq;
        logic               last;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, start lookup
        logic update;   // apply table update, build results
        logic emit1;    // present second result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] n_res;  // results for this request
    } t_sts;
endpackage

@@ rtl/core/arp_resolution_cache.sv @@
// top level of the arp resolution cache: config registers, controller, datapath
// depends on arc_pkg, arc_ctrl, arc_datapath
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata: request fields
//  m_axis  | out | tvalid/tready        | tdata: result fields, tlast: last
//  cfg     | in  | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// a request passes through capture with table match, wait, table update and first
// result, then a further result if any, each result waiting for m_axis_tready;
// the 16-entry match on the incoming request is the long path
// a stalled result holds until taken; no request is accepted meanwhile
// reset (synchronous, active low) clears every entry at once, no sweep
module arp_resolution_cache import arc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[1:0], pkt_tag[9:2], addr_kind[11:10], dest_ip[43:12],
    // hop_addr[75:44], arp_opcode[76], sender_ip[108:77], sender_mac[140:109],
    // target_ip[172:141], zero fill to 176
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // action[2:0], out_tag[10:3], mac_dest[42:11], mac_source[74:43],
    // out_arp_op[75], out_sender_ip[107:76], out_sender_mac[139:108],
    // out_target_ip[171:140], out_target_mac[203:172], link_seq[235:204], zero fill
    output logic [239:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    logic [31:0] r_own_ip, r_own_mac;
    logic        r_own_ip_valid;
    logic [3:0]  r_max_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0; r_own_mac <= '0; r_own_ip_valid <= 1'b0; r_max_req <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_IP:       r_own_ip <= i_cfg_data;
                CFG_OWN_IP_VALID: r_own_ip_valid <= i_cfg_data[0];
                CFG_OWN_MAC:      r_own_mac <= i_cfg_data;
                CFG_MAX_REQ:      r_max_req <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    t_req req;
    assign req.req_type   = s_axis_tdata[1:0];
    assign req.pkt_tag    = s_axis_tdata[9:2];
    assign req.addr_kind  = s_axis_tdata[11:10];
    assign req.dest_ip    = s_axis_tdata[43:12];
    assign req.hop_addr   = s_axis_tdata[75:44];
    assign req.arp_opcode = s_axis_tdata[76];
    assign req.sender_ip  = s_axis_tdata[108:77];
    assign req.sender_mac = s_axis_tdata[140:109];
    assign req.target_ip  = s_axis_tdata[172:141];

    t_cmd cmd;
    t_sts sts;
    t_res res;

    arc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    arc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_req(req),
        .i_own_ip(r_own_ip), .i_own_ip_valid(r_own_ip_valid),
        .i_own_mac(r_own_mac), .i_max_requests(r_max_req), .o_res(res)
    );

    assign m_axis_tdata = {4'd0, res.link_seq, res.out_target_mac, res.out_target_ip,
                           res.out_sender_mac, res.out_sender_ip, res.out_arp_op,
                           res.mac_source, res.mac_dest, res.out_tag, res.action};
    assign m_axis_tlast = res.last;
endmodule

@@ rtl/core/arc_datapath.sv @@
// table, lookup and result formation for the arp resolution cache
// depends on arc_pkg
module arc_datapath import arc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_req        i_req,
    input  logic [31:0] i_own_ip,
    input  logic        i_own_ip_valid,
    input  logic [31:0] i_own_mac,
    input  logic [3:0]  i_max_requests,
    output t_res        o_res
);
    logic [TableDepth-1:0] r_valid, r_up, r_held;
    logic [31:0]           r_ip   [TableDepth];
    logic [31:0]           r_mac  [TableDepth];
    logic [3:0]            r_cnt  [TableDepth];
    logic [TagBits-1:0]    r_htag [TableDepth];
    logic [31:0]           r_seq;

    t_req               r_req;
    logic [31:0]        r_key;
    logic               r_hit, r_free_ok;
    logic [IdxBits-1:0] r_hidx, r_fidx;
    t_res               r_res0, r_res1;
    logic [1:0]         r_n;

    // lookup key
    logic [31:0] n_key;
    always_comb begin
        n_key = (i_req.addr_kind == AT_INET) ? i_req.hop_addr : i_req.dest_ip;
        if (i_req.req_type != REQ_OUT) n_key = i_req.sender_ip;
    end

    // priority match and free slot search, registered
    logic               n_hit, n_free_ok;
    logic [IdxBits-1:0] n_hidx, n_fidx;
    always_comb begin
        n_hit = 1'b0; n_free_ok = 1'b0; n_hidx = '0; n_fidx = '0;
        for (int i = TableDepth - 1; i >= 0; i--) begin
            if (r_valid[i] && r_ip[i] == n_key) begin
                n_hit = 1'b1; n_hidx = IdxBits'(i);
            end
            if (!r_valid[i]) begin
                n_free_ok = 1'b1; n_fidx = IdxBits'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req; r_key <= n_key;
            r_hit <= n_hit; r_hidx <= n_hidx;
            r_free_ok <= n_free_ok; r_fidx <= n_fidx;
        end
    end

    // update step: next contents of the chosen entry and the results
    logic [IdxBits-1:0] e;
    logic               e_ok, e_new, e_up, e_held;
    logic [3:0]         e_cnt;
    logic [31:0]        seq1;
    t_res               blank, rq, fin;
    logic               n_we, n_up, n_held, n_clear;
    logic [31:0]        n_mac, n_seq;
    logic [3:0]         n_cnt;
    logic [TagBits-1:0] n_htag;
    t_res               n_res0, n_res1;
    logic [1:0]         n_n;
    always_comb begin
        e      = r_hit ? r_hidx : r_fidx;
        e_ok   = r_hit || r_free_ok;
        e_new  = !r_hit;
        e_up   = e_new ? 1'b0 : r_up[e];
        e_held = e_new ? 1'b0 : r_held[e];
        e_cnt  = e_new ? 4'd0 : r_cnt[e];
        seq1   = r_seq + 32'd1;
        blank  = '0;
        blank.mac_source = i_own_mac;

        n_we    = 1'b0;
        n_clear = 1'b0;
        n_mac   = e_new ? 32'd0 : r_mac[e];
        n_up    = e_up;
        n_held  = e_held;
        n_cnt   = e_cnt;
        n_htag  = e_new ? '0 : r_htag[e];
        n_seq   = r_seq;
        n_res0  = blank;
        n_res1  = blank;
        n_n     = 2'd0;

        // arp request for the looked-up address
        rq = blank;
        rq.action         = ACT_REQUEST;
        rq.mac_dest       = BCAST;
        rq.out_sender_ip  = i_own_ip_valid ? i_own_ip : 32'd0;
        rq.out_sender_mac = i_own_mac;
        rq.out_target_ip  = r_key;
        rq.last           = 1'b1;

        // final result of a received arp: reply or free
        fin = blank;
        fin.out_tag = r_req.pkt_tag;
        fin.last    = 1'b1;
        if (!r_req.arp_opcode && i_own_ip_valid && r_req.target_ip == i_own_ip) begin
            fin.action         = ACT_REPLY;
            fin.mac_dest       = r_req.sender_mac;
            fin.out_arp_op     = 1'b1;
            fin.out_sender_ip  = r_req.target_ip;
            fin.out_sender_mac = i_own_mac;
            fin.out_target_ip  = r_req.sender_ip;
            fin.out_target_mac = r_req.sender_mac;
        end else begin
            fin.action = ACT_FREE;
        end

        case (r_req.req_type) inside
            REQ_OUT: begin
                n_seq = seq1;
                n_n   = 2'd1;
                n_res0.out_tag  = r_req.pkt_tag;
                n_res0.link_seq = seq1;
                n_res0.last     = 1'b1;
                if (r_req.addr_kind == AT_ILINK) begin
                    n_res0.mac_dest = r_req.hop_addr;
                end else if (r_req.addr_kind == AT_OTHER || r_key == BCAST) begin
                    n_res0.mac_dest = BCAST;
                end else if (r_hit && e_up) begin
                    n_res0.mac_dest = r_mac[e];
                end else if (!e_ok) begin
                    n_res0.action = ACT_DROP;
                end else begin
                    n_we = 1'b1;
                    if (e_cnt >= i_max_requests) begin
                        // retries used up: drop held and new packet
                        n_cnt  = 4'd0;
                        n_held = 1'b0;
                        n_res0.action = ACT_DROP;
                        if (e_held) begin
                            n_n = 2'd2;
                            n_res0.out_tag  = r_htag[e];
                            n_res0.link_seq = '0;
                            n_res0.last     = 1'b0;
                            n_res1.action   = ACT_DROP;
                            n_res1.out_tag  = r_req.pkt_tag;
                            n_res1.link_seq = seq1;
                            n_res1.last     = 1'b1;
                        end
                    end else begin
                        n_cnt  = e_cnt + 4'd1;
                        n_held = 1'b1;
                        n_htag = r_req.pkt_tag;
                        if (e_held) begin
                            n_n = 2'd2;
                            n_res0.action   = ACT_DROP;
                            n_res0.out_tag  = r_htag[e];
                            n_res0.link_seq = '0;
                            n_res0.last     = 1'b0;
                            n_res1 = rq;
                        end else begin
                            n_res0 = rq;
                        end
                    end
                end
            end
            REQ_ARP, REQ_ADD: begin
                if (e_ok) begin
                    n_we  = 1'b1;
                    n_mac = r_req.sender_mac;
                    n_up  = 1'b1;
                    if (r_req.req_type == REQ_ARP) n_held = 1'b0;
                end
                if (r_req.req_type == REQ_ARP) begin
                    if (e_ok && e_held) begin
                        n_n = 2'd2;
                        n_res0.action   = ACT_SEND_HELD;
                        n_res0.out_tag  = r_htag[e];
                        n_res0.mac_dest = r_req.sender_mac;
                        n_res1 = fin;
                    end else begin
                        n_n = 2'd1;
                        n_res0 = fin;
                    end
                end
            end
            default: begin
                n_clear = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_up <= '0; r_held <= '0; r_seq <= '0;
            r_n <= '0;
        end else if (i_cmd.update) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
            r_n    <= n_n;
            r_seq  <= n_seq;
            if (n_clear) begin
                r_valid <= '0; r_up <= '0; r_held <= '0;
                for (int i = 0; i < TableDepth; i++) r_cnt[i] <= 4'd0;
            end else if (n_we) begin
                r_valid[e] <= 1'b1;
                r_ip[e]    <= r_key;
                r_mac[e]   <= n_mac;
                r_up[e]    <= n_up;
                r_held[e]  <= n_held;
                r_cnt[e]   <= n_cnt;
                r_htag[e]  <= n_htag;
            end
        end
    end

    assign o_sts.n_res = r_n;
    assign o_res = i_cmd.emit1 ? r_res1 : r_res0;
endmodule

@@ rtl/core/arc_ctrl.sv @@
// sequencing state machine for the arp resolution cache
// depends on arc_pkg and the assertion macro header
`include "arp_resolution_cache_macros.svh"
module arc_ctrl import arc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_UPD, S_OUT0, S_OUT1} t_state;
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LOOK;
            S_LOOK: n_state = S_UPD;
            S_UPD:  n_state = S_OUT0;
            S_OUT0: begin
                if (i_sts.n_res == 2'd0) n_state = S_IDLE;
                else if (i_out_ready)
                    n_state = (i_sts.n_res == 2'd2) ? S_OUT1 : S_IDLE;
            end
            S_OUT1: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.update = (r_state == S_UPD);
    assign o_cmd.emit1  = (r_state == S_OUT1);
    assign o_out_valid  = (r_state == S_OUT1) ||
                          ((r_state == S_OUT0) && i_sts.n_res != 2'd0);

    `ARC_ASSERT_NEXT(a_load_seq, i_clk, i_rst_n, o_cmd.load, r_state == S_LOOK,
        "load not followed by lookup")
    `ARC_ASSERT_IMPL(a_out_idle, i_clk, i_rst_n, o_out_valid, !o_in_ready,
        "input accepted while result pending")
    `ARC_ASSERT_NEXT(a_second, i_clk, i_rst_n, r_state == S_OUT1 && !i_out_ready,
        o_out_valid, "second result lost")
endmodule
